>>> hdl/s2cd_pkg.sv
`default_nettype none

package s2cd_pkg;

   // pipeline depth, input register to result register
   localparam int NUM_STAGES = 12;

   // register stage of each step
   localparam int ST_IN   = 0;
   localparam int ST_QH   = 1;
   localparam int ST_RH   = 2;
   localparam int ST_QL   = 3;
   localparam int ST_DAYS = 4;
   localparam int ST_ERA  = 5;
   localparam int ST_DOE  = 6;
   localparam int ST_T    = 7;
   localparam int ST_YOE  = 8;
   localparam int ST_DOY  = 9;
   localparam int ST_MP   = 10;
   localparam int ST_OUT  = 11;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   // bias the signed seconds by a whole number of days so the value is never negative
   localparam longint unsigned SECS_BIAS_DAYS = ((64'd1 << 47) + 64'd86399) / 64'd86400;
   localparam logic [49:0] SECS_BIAS = 50'(SECS_BIAS_DAYS * 64'd86400);

   // whole eras added so the shifted day count (day zero at 0000-03-01) stays positive
   localparam longint unsigned ERA_BIAS =
      (SECS_BIAS_DAYS - 64'd719468 + 64'd146096) / 64'd146097;
   localparam logic [31:0] DAY_BIAS =
      32'(ERA_BIAS * 64'd146097 + 64'd719468 - SECS_BIAS_DAYS);
   localparam logic signed [15:0] ERA_BIAS_W = 16'(ERA_BIAS);

   // reciprocals, ceil(2^s / d), exact for the stated operand width
   localparam logic [21:0] RCP_675_A = 22'(((64'd1 << 31) + 64'd674) / 64'd675);
   localparam logic [31:0] RCP_675_B = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
   localparam logic [32:0] RCP_ERA   = 33'(((64'd1 << 50) + 64'd146096) / 64'd146097);
   localparam logic [18:0] RCP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RCP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
   localparam logic [18:0] RCP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [9:0]  RCP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
   localparam logic [11:0] RCP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [17:0] RCP_3600  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [12:0] RCP_60    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

   // last day of an era, the extra leap day of the 400th year
   localparam logic [17:0] DOE_LAST = 18'd146096;

   // march-based month index of january
   localparam logic [3:0] MP_JAN = 4'd10;

   // first day of year (from march 1) of each march-based month
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] offs;
      case (mp)
         4'd0:    offs = 9'd0;
         4'd1:    offs = 9'd31;
         4'd2:    offs = 9'd61;
         4'd3:    offs = 9'd92;
         4'd4:    offs = 9'd122;
         4'd5:    offs = 9'd153;
         4'd6:    offs = 9'd184;
         4'd7:    offs = 9'd214;
         4'd8:    offs = 9'd245;
         4'd9:    offs = 9'd275;
         4'd10:   offs = 9'd306;
         4'd11:   offs = 9'd337;
         default: offs = 9'd0;
      endcase
      return offs;
   endfunction

endpackage

`default_nettype wire

>>> hdl/s2cd_pipe_ctrl.sv
`default_nettype none

module s2cd_pipe_ctrl
   import s2cd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output stage_vec_type load
);

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type ready_vec;
   stage_vec_type upstream;

   // a stage may take new data if the output drains or it or any later stage holds a bubble
   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         ready_vec[k] = rsp_ready || !(&(valid_ff | stage_vec_type'((1 << k) - 1)));
      end
      upstream = {valid_ff[NUM_STAGES-2:0], req_valid};
      valid_in = (ready_vec & upstream) | (~ready_vec & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_vec[ST_IN];
   assign rsp_valid = valid_ff[ST_OUT];
   assign load      = ready_vec;

endmodule

`default_nettype wire

>>> hdl/s2cd_day_split.sv
`default_nettype none

module s2cd_day_split
   import s2cd_pkg::*;
(
   input  wire logic               clock,
   input  wire stage_vec_type      load,
   input  wire logic signed [47:0] seconds,
   output logic [31:0]             day_index,
   output logic [16:0]             day_second
);

   logic signed [47:0] secs_ff;

   logic [49:0] biased;
   logic [41:0] coarse;
   logic [42:0] qh_prod;
   logic [11:0] qh1_in;
   logic [11:0] qh1_ff, qh2_ff, qh3_ff;
   logic [20:0] vh1_ff;
   logic [20:0] vl1_ff, vl2_ff;
   logic [6:0]  r7_1_ff, r7_2_ff, r7_3_ff;

   logic [20:0] rh_full;
   logic [9:0]  rh2_ff;

   logic [30:0] w_in;
   logic [62:0] ql_prod;
   logic [20:0] ql3_ff;
   logic [30:0] w3_ff;

   logic [30:0] rl_full;
   logic [32:0] day_in;
   logic [31:0] day_index_ff;
   logic [16:0] day_second_ff;

   // u = seconds + bias, then u / 86400 as (u >> 7) / 675 in two halves
   always_comb begin
      biased  = 50'(secs_ff) + SECS_BIAS;
      coarse  = biased[48:7];
      qh_prod = 43'(coarse[41:21]) * 43'(RCP_675_A);
      qh1_in  = qh_prod[42:31];
   end

   always_comb begin
      rh_full = vh1_ff - 21'(21'(qh1_ff) * 21'd675);
   end

   always_comb begin
      w_in    = {rh2_ff, vl2_ff};
      ql_prod = 63'(w_in) * 63'(RCP_675_B);
   end

   always_comb begin
      rl_full = w3_ff - 31'(31'(ql3_ff) * 31'd675);
      day_in  = {qh3_ff, ql3_ff} + 33'(DAY_BIAS);
   end

   always_ff @(posedge clock) begin
      if (load[ST_IN]) begin
         secs_ff <= seconds;
      end
      if (load[ST_QH]) begin
         qh1_ff  <= qh1_in;
         vh1_ff  <= coarse[41:21];
         vl1_ff  <= coarse[20:0];
         r7_1_ff <= biased[6:0];
      end
      if (load[ST_RH]) begin
         qh2_ff  <= qh1_ff;
         rh2_ff  <= rh_full[9:0];
         vl2_ff  <= vl1_ff;
         r7_2_ff <= r7_1_ff;
      end
      if (load[ST_QL]) begin
         qh3_ff  <= qh2_ff;
         ql3_ff  <= ql_prod[61:41];
         w3_ff   <= w_in;
         r7_3_ff <= r7_2_ff;
      end
      if (load[ST_DAYS]) begin
         day_index_ff  <= day_in[31:0];
         day_second_ff <= {rl_full[9:0], r7_3_ff};
      end
   end

   assign day_index  = day_index_ff;
   assign day_second = day_second_ff;

endmodule

`default_nettype wire

>>> hdl/s2cd_clock.sv
`default_nettype none

module s2cd_clock
   import s2cd_pkg::*;
(
   input  wire logic          clock,
   input  wire stage_vec_type load,
   input  wire logic [16:0]   day_second,
   output logic [4:0]         hour,
   output logic [5:0]         minute,
   output logic [5:0]         second
);

   logic [34:0] hour_prod;
   logic [4:0]  hr5_ff, hr6_ff, hr7_ff, hr8_ff, hr9_ff, hr10_ff, hour_ff;
   logic [16:0] sod5_ff;
   logic [16:0] rem_full;
   logic [11:0] rem6_ff, rem7_ff;
   logic [24:0] min_prod;
   logic [5:0]  mn7_ff, mn8_ff, mn9_ff, mn10_ff, minute_ff;
   logic [11:0] sec_full;
   logic [5:0]  sc8_ff, sc9_ff, sc10_ff, second_ff;

   always_comb begin
      hour_prod = 35'(day_second) * 35'(RCP_3600);
      rem_full  = sod5_ff - 17'(17'(hr5_ff) * 17'd3600);
      min_prod  = 25'(rem6_ff) * 25'(RCP_60);
      sec_full  = rem7_ff - 12'(12'(mn7_ff) * 12'd60);
   end

   always_ff @(posedge clock) begin
      if (load[ST_ERA]) begin
         hr5_ff  <= hour_prod[33:29];
         sod5_ff <= day_second;
      end
      if (load[ST_DOE]) begin
         hr6_ff  <= hr5_ff;
         rem6_ff <= rem_full[11:0];
      end
      if (load[ST_T]) begin
         hr7_ff  <= hr6_ff;
         rem7_ff <= rem6_ff;
         mn7_ff  <= min_prod[23:18];
      end
      if (load[ST_YOE]) begin
         hr8_ff <= hr7_ff;
         mn8_ff <= mn7_ff;
         sc8_ff <= sec_full[5:0];
      end
      // delay to line up with the calendar path
      if (load[ST_DOY]) begin
         hr9_ff <= hr8_ff;
         mn9_ff <= mn8_ff;
         sc9_ff <= sc8_ff;
      end
      if (load[ST_MP]) begin
         hr10_ff <= hr9_ff;
         mn10_ff <= mn9_ff;
         sc10_ff <= sc9_ff;
      end
      if (load[ST_OUT]) begin
         hour_ff   <= hr10_ff;
         minute_ff <= mn10_ff;
         second_ff <= sc10_ff;
      end
   end

   assign hour   = hour_ff;
   assign minute = minute_ff;
   assign second = second_ff;

endmodule

`default_nettype wire

>>> hdl/s2cd_calendar.sv
`default_nettype none

module s2cd_calendar
   import s2cd_pkg::*;
(
   input  wire logic          clock,
   input  wire stage_vec_type load,
   input  wire logic [31:0]   day_index,
   output logic signed [23:0] year,
   output logic [3:0]         month,
   output logic [4:0]         day
);

   logic [64:0] era_prod;
   logic [14:0] era5_ff;
   logic [31:0] idx5_ff;

   logic [31:0]        doe_full;
   logic signed [15:0] era_rel;
   logic signed [24:0] base_full;
   logic [17:0]        doe6_ff, doe7_ff, doe8_ff;
   logic signed [23:0] base6_ff, base7_ff, base8_ff;

   logic [36:0] c4_prod;
   logic [36:0] c100_prod;
   logic [17:0] t_in;
   logic [17:0] t7_ff;

   logic [36:0] yoe_prod;
   logic [8:0]  yoe8_ff;

   logic [18:0]        cent_prod;
   logic [17:0]        year_start;
   logic [17:0]        doy_full;
   logic [10:0]        x5_in;
   logic [8:0]         doy9_ff, doy10_ff;
   logic [10:0]        x5_9_ff;
   logic signed [23:0] year9_ff, year10_ff;

   logic [22:0] mp_prod;
   logic [3:0]  mp10_ff;

   logic [8:0]         dom_full;
   logic signed [23:0] year_ff;
   logic [3:0]         month_ff;
   logic [4:0]         day_ff;

   // era and day of era
   always_comb begin
      era_prod  = 65'(day_index) * 65'(RCP_ERA);
      doe_full  = idx5_ff - 32'(32'(era5_ff) * 32'd146097);
      era_rel   = signed'(16'(era5_ff)) - ERA_BIAS_W;
      base_full = 25'(era_rel) * 25'sd400;
   end

   // year of era: (doe - doe/1460 + doe/36524 - doe/146096) / 365
   always_comb begin
      c4_prod   = 37'(doe6_ff) * 37'(RCP_1460);
      c100_prod = 37'(doe6_ff) * 37'(RCP_36524);
      t_in      = doe6_ff - 18'(c4_prod[35:29]) + 18'(c100_prod[36:34])
                  - 18'(doe6_ff == DOE_LAST);
      yoe_prod  = 37'(t7_ff) * 37'(RCP_365);
   end

   // day of year from march 1, and 5 * doy + 2 for the month split
   always_comb begin
      cent_prod  = 19'(yoe8_ff) * 19'(RCP_100);
      year_start = 18'(18'(yoe8_ff) * 18'd365) + 18'(yoe8_ff[8:2]) - 18'(cent_prod[18:16]);
      doy_full   = doe8_ff - year_start;
      x5_in      = 11'(11'(doy_full[8:0]) * 11'd5) + 11'd2;
      mp_prod    = 23'(x5_9_ff) * 23'(RCP_153);
   end

   always_comb begin
      dom_full = doy10_ff - month_start(mp10_ff) + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (load[ST_ERA]) begin
         era5_ff <= era_prod[64:50];
         idx5_ff <= day_index;
      end
      if (load[ST_DOE]) begin
         doe6_ff  <= doe_full[17:0];
         base6_ff <= base_full[23:0];
      end
      if (load[ST_T]) begin
         t7_ff    <= t_in;
         doe7_ff  <= doe6_ff;
         base7_ff <= base6_ff;
      end
      if (load[ST_YOE]) begin
         yoe8_ff  <= yoe_prod[35:27];
         doe8_ff  <= doe7_ff;
         base8_ff <= base7_ff;
      end
      if (load[ST_DOY]) begin
         doy9_ff  <= doy_full[8:0];
         x5_9_ff  <= x5_in;
         year9_ff <= base8_ff + 24'(yoe8_ff);
      end
      if (load[ST_MP]) begin
         mp10_ff   <= mp_prod[22:19];
         doy10_ff  <= doy9_ff;
         year10_ff <= year9_ff;
      end
      if (load[ST_OUT]) begin
         day_ff <= dom_full[4:0];
         // january and february close the march-based year
         if (mp10_ff < MP_JAN) begin
            month_ff <= mp10_ff + 4'd3;
            year_ff  <= year10_ff;
         end else begin
            month_ff <= mp10_ff - 4'd9;
            year_ff  <= year10_ff + 24'sd1;
         end
      end
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;

endmodule

`default_nettype wire

>>> hdl/seconds_to_civil_datetime.sv
// Converts a signed 48-bit count of seconds since 1970-01-01 00:00:00 (no time zone) into a
// proleptic Gregorian date (astronomical year, month 1..12, day 1..31) and hour, minute,
// second; negative inputs use floor division so the time of day is never negative, and every
// 48-bit pattern gives a valid result. The block holds no state: one result per item, in order.
// It is a 12-register pipeline: an item accepted on req_* passes every register to rsp_*, and a
// new item can be accepted every cycle while rsp_ready is high or a stage holds a bubble. The
// depth comes from the chain of constant divisions (by 86400, by the 146097-day era, by 365 and
// by 153), each done as a reciprocal multiply followed by a register. Input and output are
// parted by the pipeline registers: while a result waits on rsp_ready, req_ready stays high as
// long as any stage holds a bubble, and it drops only when every stage is full.

`default_nettype none

module seconds_to_civil_datetime
   import s2cd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   // item in
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [47:0] req_seconds,

   // item out
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_year,
   output logic [3:0]              rsp_month,
   output logic [4:0]              rsp_day,
   output logic [4:0]              rsp_hour,
   output logic [5:0]              rsp_minute,
   output logic [5:0]              rsp_second
);

   // per-stage load enables, one per pipeline register rank
   stage_vec_type load;

   // day split results: biased day count and seconds of the day
   logic [31:0] day_index;
   logic [16:0] day_second;

   // valid bits and stall logic for all stages
   s2cd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .load      (load)
   );

   // seconds -> whole days and seconds of the day (floor)
   s2cd_day_split u_days (
      .clock      (clock),
      .load       (load),
      .seconds    (req_seconds),
      .day_index  (day_index),
      .day_second (day_second)
   );

   // day count -> year, month, day through 400-year eras
   s2cd_calendar u_cal (
      .clock     (clock),
      .load      (load),
      .day_index (day_index),
      .year      (rsp_year),
      .month     (rsp_month),
      .day       (rsp_day)
   );

   // seconds of the day -> hour, minute, second, delayed to match the date
   s2cd_clock u_clk (
      .clock      (clock),
      .load       (load),
      .day_second (day_second),
      .hour       (rsp_hour),
      .minute     (rsp_minute),
      .second     (rsp_second)
   );

endmodule

`default_nettype wire

>>> hdl/s2cd_checker.sv
`default_nettype none

module s2cd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [23:0] rsp_year,
   input wire logic [3:0]         rsp_month,
   input wire logic [4:0]         rsp_day,
   input wire logic [4:0]         rsp_hour,
   input wire logic [5:0]         rsp_minute,
   input wire logic [5:0]         rsp_second
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the input stalls only when every stage is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the pipeline could move");

   // every result has month 1..12, day at least 1 and a legal time of day
   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 &&
                     rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("result field out of range");

   // a blocked result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_year) &&
         $stable(rsp_month) && $stable(rsp_day) && $stable(rsp_hour) &&
         $stable(rsp_minute) && $stable(rsp_second)))
      else $error("blocked result changed");

endmodule

bind seconds_to_civil_datetime s2cd_checker u_checker (.*);

`default_nettype wire
